// File: rtl/cpio_pkg.sv
// Package: constants and access codes for the CPU I/O port core.
package cpio_pkg;

    localparam int unsigned FALLOFF_W   = 20;
    localparam int unsigned NOW_W       = 47;
    localparam int unsigned DEADLINE_W  = 48;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [FALLOFF_W-1:0] FALLOFF_RESET = 20'd350000;

    localparam logic [7:0] DIR_RESET      = 8'h00;
    localparam logic [7:0] DATA_RESET     = 8'h3f;
    localparam logic [7:0] PINS_RESET     = 8'h3f;
    localparam logic [7:0] READBACK_RESET = 8'h1f;

    localparam logic [7:0] PIN_PULL_MASK  = 8'h17;
    localparam logic [7:0] BIT5_CLR_MASK  = 8'hdf;
    localparam logic [7:0] MOTOR_MASK     = 8'h20;
    localparam logic [7:0] TAPE_WR_MASK   = 8'h08;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic SEL_DIR  = 1'b0;
    localparam logic SEL_DATA = 1'b1;

    // word index of the falloff register on the APB port
    localparam logic REG_FALLOFF = 1'b0;

endpackage

// File: rtl/cpu_io_port_with_bit_falloff_core.sv
// CPU I/O port core: direction/data registers with decay of floating bits 6 and 7.
// Pipeline: input register, then result register.
// Throughput: one item per cycle unless m_valid is held high with m_ready low; the single
// update path between the two registers (one 48-bit deadline add or compare) sets that rate.
// Reset (aresetn low, synchronous): pipeline empty, port registers at power-on values,
// falloff_cycles = 350000, decay bits clear; deadlines are written before use.
module cpu_io_port_with_bit_falloff_core
    import cpio_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic                  s_reg_select,
    input  logic [7:0]            s_write_value,
    input  logic [NOW_W-1:0]      s_now,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_read_data,
    output logic [7:0]            m_map_port_value,
    output logic                  m_motor_line,
    output logic                  m_tape_write_line
);

    // configuration
    logic [FALLOFF_W-1:0] falloff_reg;

    // input register
    logic             in_valid_reg;
    logic             in_op_reg;
    logic             in_sel_reg;
    logic [7:0]       in_val_reg;
    logic [NOW_W-1:0] in_now_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_rd_reg;
    logic [7:0] out_map_reg;
    logic       out_motor_reg;
    logic       out_tape_reg;

    // port state
    logic [7:0] dir_reg, dir_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] pins_reg, pins_next;
    logic [7:0] readback_reg, readback_next;
    logic [1:0] high_valid_reg, high_valid_next;
    logic [1:0] decaying_reg, decaying_next;
    logic [DEADLINE_W-1:0] deadline_reg [2];
    logic [1:0]            deadline_we;
    logic [DEADLINE_W-1:0] deadline_new;

    logic       advance;
    logic       cfg_wr;
    logic [7:0] rd_next;
    logic [7:0] map_next;
    logic [7:0] rd_mask;
    logic       is_dir_write;
    logic       is_data_write;
    logic       is_data_read;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_FALLOFF)
                   ? {{(APB_DATA_W-FALLOFF_W){1'b0}}, falloff_reg} : '0;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign is_dir_write  = (in_op_reg == OP_WRITE) && (in_sel_reg == SEL_DIR);
    assign is_data_write = (in_op_reg == OP_WRITE) && (in_sel_reg == SEL_DATA);
    assign is_data_read  = (in_op_reg == OP_READ)  && (in_sel_reg == SEL_DATA);
    assign deadline_new  = {1'b0, in_now_reg} + {{(DEADLINE_W-FALLOFF_W){1'b0}}, falloff_reg};

    always_comb begin
        dir_next        = dir_reg;
        data_next       = data_reg;
        pins_next       = pins_reg;
        readback_next   = readback_reg;
        high_valid_next = high_valid_reg;
        decaying_next   = decaying_reg;
        deadline_we     = 2'b00;
        rd_next         = 8'h00;
        rd_mask         = 8'hff;

        if (is_dir_write) begin
            for (int i = 0; i < 2; i++) begin
                if (high_valid_reg[i] && !in_val_reg[6+i] && !decaying_reg[i]) begin
                    decaying_next[i] = 1'b1;
                    deadline_we[i]   = 1'b1;
                end else if (high_valid_reg[i] && in_val_reg[6+i] && decaying_reg[i]) begin
                    decaying_next[i] = 1'b0;
                end
            end
            dir_next = in_val_reg;
        end else if (is_data_write) begin
            for (int i = 0; i < 2; i++) begin
                if (dir_reg[6+i] && in_val_reg[6+i]) begin
                    high_valid_next[i] = 1'b1;
                end
            end
            data_next = in_val_reg;
        end else if (in_op_reg == OP_READ && in_sel_reg == SEL_DIR) begin
            rd_next = dir_reg;
        end else if (is_data_read) begin
            for (int i = 0; i < 2; i++) begin
                // a decaying bit expires once its deadline lies strictly in the past
                if (decaying_reg[i] && (deadline_reg[i] < {1'b0, in_now_reg})) begin
                    decaying_next[i]   = 1'b0;
                    high_valid_next[i] = 1'b0;
                end
                if (!high_valid_next[i]) begin
                    rd_mask[6+i] = 1'b0;
                end
            end
            rd_next = readback_reg & rd_mask;
        end

        if (in_op_reg == OP_WRITE) begin
            pins_next     = (pins_reg & ~dir_next) | (data_next & dir_next);
            readback_next = (data_next | ~dir_next) & (pins_next | PIN_PULL_MASK);
            if ((dir_next & MOTOR_MASK) == 8'h00) begin
                readback_next = readback_next & BIT5_CLR_MASK;
            end
        end

        map_next = (data_next | ~dir_next) & (pins_next | PIN_PULL_MASK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            falloff_reg    <= FALLOFF_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            dir_reg        <= DIR_RESET;
            data_reg       <= DATA_RESET;
            pins_reg       <= PINS_RESET;
            readback_reg   <= READBACK_RESET;
            high_valid_reg <= 2'b00;
            decaying_reg   <= 2'b00;
        end else begin
            if (cfg_wr && paddr[2] == REG_FALLOFF) begin
                falloff_reg <= pwdata[FALLOFF_W-1:0];
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                dir_reg        <= dir_next;
                data_reg       <= data_next;
                pins_reg       <= pins_next;
                readback_reg   <= readback_next;
                high_valid_reg <= high_valid_next;
                decaying_reg   <= decaying_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg  <= s_op;
            in_sel_reg <= s_reg_select;
            in_val_reg <= s_write_value;
            in_now_reg <= s_now;
        end
        if (advance) begin
            out_rd_reg    <= rd_next;
            out_map_reg   <= map_next;
            out_motor_reg <= ((dir_next & data_next & MOTOR_MASK) != 8'h00);
            out_tape_reg  <= (((~dir_next | data_next) & TAPE_WR_MASK) != 8'h00);
            for (int i = 0; i < 2; i++) begin
                if (deadline_we[i]) begin
                    deadline_reg[i] <= deadline_new;
                end
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_read_data       = out_rd_reg;
    assign m_map_port_value  = out_map_reg;
    assign m_motor_line      = out_motor_reg;
    assign m_tape_write_line = out_tape_reg;

endmodule
